### sv/erm_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// erm_pkg: shared constants, types and functions of the rotation matrix block
// Holds the CORDIC arctangent table, the working widths and the record
// that travels down the chain of CORDIC cells.
// ---------------------------------------------------------------------------
package erm_pkg;

  localparam int FracBitsDef     = 14;
  localparam int CordicStagesDef = 16;
  localparam int WorkBits        = 48;
  localparam int AngleBits       = 16;
  localparam int ElemBits        = 16;
  localparam int PhaseBits       = 32;
  localparam longint unsigned FullTurnCenti = 64'd36000;
  localparam logic [WorkBits-1:0] GainStart = 48'd2608131496 << 16;

  // Width of the CORDIC x/y datapath with head room for gain growth.
  localparam int XyBits = WorkBits + 2;
  localparam int ZBits  = 33;

  typedef logic [1:0] quad_t;

  // One angle's CORDIC state as it moves from cell to cell.
  typedef struct packed {
    logic signed [XyBits-1:0] x;
    logic signed [XyBits-1:0] y;
    logic signed [ZBits-1:0]  z;
    quad_t                    quad;
  } rot_t;

  function automatic logic signed [ZBits-1:0] atan_turn(input int idx);
    logic [31:0] v;
    case (idx)
      0: v = 32'd536870912;   1: v = 32'd316933406;  2: v = 32'd167458907;
      3: v = 32'd85004756;    4: v = 32'd42667331;   5: v = 32'd21354465;
      6: v = 32'd10679838;    7: v = 32'd5340245;    8: v = 32'd2670163;
      9: v = 32'd1335087;    10: v = 32'd667544;    11: v = 32'd333772;
      12: v = 32'd166886;    13: v = 32'd83443;     14: v = 32'd41722;
      15: v = 32'd20861;     16: v = 32'd10430;     17: v = 32'd5215;
      18: v = 32'd2608;      19: v = 32'd1304;      20: v = 32'd652;
      21: v = 32'd326;       22: v = 32'd163;       23: v = 32'd81;
      24: v = 32'd41;        25: v = 32'd20;        26: v = 32'd10;
      27: v = 32'd5;         28: v = 32'd3;         29: v = 32'd1;
      30: v = 32'd1;
      default: v = 32'd0;
    endcase
    return $signed({1'b0, v});
  endfunction

endpackage : erm_pkg
`default_nettype wire

### sv/euler_rotation_matrix.sv
`default_nettype none
// ---------------------------------------------------------------------------
// euler_rotation_matrix: roll-pitch-yaw angles to a 3x3 rotation matrix
// Computes R = Rz*Ry*Rx from three angles in hundredths of a degree.
// ---------------------------------------------------------------------------
// Usage:
//   Drive angle_x_i, angle_y_i and angle_z_i and raise start_i. A beat is
//   taken on any edge where start_i is high and busy_o is low; busy_o is
//   always low, so one angle triple is taken every cycle.
//   Each angle goes through a phase unit, a chain of CORDIC_STAGES
//   registered rotation cells (at most 32) and a fold-back register,
//   then three product and sum stages. Throughput is one triple per cycle.
//   The nine Q1.14 elements appear for exactly one cycle with done_o high.
//   The receiver cannot stall; every result must be taken when shown.
//   Reset clears only the valid pipeline; data registers carry no reset.
// ---------------------------------------------------------------------------
module euler_rotation_matrix #(
  parameter int FRAC_BITS     = erm_pkg::FracBitsDef,
  parameter int CORDIC_STAGES = erm_pkg::CordicStagesDef
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  output logic                               busy_o,
  input  wire logic [erm_pkg::AngleBits-1:0] angle_x_i,
  input  wire logic [erm_pkg::AngleBits-1:0] angle_y_i,
  input  wire logic [erm_pkg::AngleBits-1:0] angle_z_i,
  output logic                               done_o,
  output logic [erm_pkg::ElemBits-1:0]       elem_r0c0_o,
  output logic [erm_pkg::ElemBits-1:0]       elem_r0c1_o,
  output logic [erm_pkg::ElemBits-1:0]       elem_r0c2_o,
  output logic [erm_pkg::ElemBits-1:0]       elem_r1c0_o,
  output logic [erm_pkg::ElemBits-1:0]       elem_r1c1_o,
  output logic [erm_pkg::ElemBits-1:0]       elem_r1c2_o,
  output logic [erm_pkg::ElemBits-1:0]       elem_r2c0_o,
  output logic [erm_pkg::ElemBits-1:0]       elem_r2c1_o,
  output logic [erm_pkg::ElemBits-1:0]       elem_r2c2_o
);

  localparam int NCells  = (CORDIC_STAGES > 32) ? 32 : CORDIC_STAGES;
  localparam int Latency = NCells + 6;
  localparam int W       = FRAC_BITS + 2;

  logic signed [W-1:0] sx, cx, sy, cy, sz, cz;
  logic [erm_pkg::ElemBits-1:0] elem [9];
  logic [Latency-1:0] vld_q;

  assign busy_o = 1'b0;

  erm_sincos #(.FRAC_BITS(FRAC_BITS), .CORDIC_STAGES(CORDIC_STAGES)) u_sc_x (
    .clk_i(clk_i), .angle_i(angle_x_i), .sin_o(sx), .cos_o(cx));
  erm_sincos #(.FRAC_BITS(FRAC_BITS), .CORDIC_STAGES(CORDIC_STAGES)) u_sc_y (
    .clk_i(clk_i), .angle_i(angle_y_i), .sin_o(sy), .cos_o(cy));
  erm_sincos #(.FRAC_BITS(FRAC_BITS), .CORDIC_STAGES(CORDIC_STAGES)) u_sc_z (
    .clk_i(clk_i), .angle_i(angle_z_i), .sin_o(sz), .cos_o(cz));

  erm_matrix #(.FRAC_BITS(FRAC_BITS)) u_matrix (
    .clk_i(clk_i), .sx_i(sx), .cx_i(cx), .sy_i(sy), .cy_i(cy),
    .sz_i(sz), .cz_i(cz), .elem_o(elem));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[Latency-2:0], start_i & ~busy_o};
    end
  end

  assign done_o      = vld_q[Latency-1];
  assign elem_r0c0_o = elem[0];
  assign elem_r0c1_o = elem[1];
  assign elem_r0c2_o = elem[2];
  assign elem_r1c0_o = elem[3];
  assign elem_r1c1_o = elem[4];
  assign elem_r1c2_o = elem[5];
  assign elem_r2c0_o = elem[6];
  assign elem_r2c1_o = elem[7];
  assign elem_r2c2_o = elem[8];

  // A beat taken now leaves when it reaches the end of the valid pipeline.
  a_done_follows_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[0] |-> ##(Latency-1) done_o) else $error("lost beat");
  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !vld_q[0] |-> ##(Latency-1) !done_o) else $error("invented beat");
  a_never_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_o) else $error("busy raised");

endmodule : euler_rotation_matrix
`default_nettype wire

### sv/erm_phase.sv
`default_nettype none
// ---------------------------------------------------------------------------
// erm_phase: angle to CORDIC start record
// Reduces the angle modulo a full turn, scales it to 2^-32 turn by a
// constant reciprocal and registers the first cell input.
// ---------------------------------------------------------------------------
module erm_phase (
  input  wire logic                                 clk_i,
  input  wire logic [erm_pkg::AngleBits-1:0]        angle_i,
  output erm_pkg::rot_t                             rot_o
);

  // 2^32 = 36000 * TurnQuot + 32 * RemScaled, and 18000 = 32 * HalfScaled + 16.
  localparam logic [16:0] TurnQuot   = 17'd119304;
  localparam logic [9:0]  RemScaled  = 10'd728;
  localparam logic [9:0]  HalfScaled = 10'd562;
  // ceil(2^35 / 1125); exact for every dividend below 2^25.
  localparam logic [24:0] RecipMul   = 25'd30541990;
  localparam int          RecipShift = 35;

  logic [erm_pkg::AngleBits-1:0] wrapped;
  logic [31:0]                   base_d, base_q;
  logic [24:0]                   rem_d, rem_q;
  logic [49:0]                   prod;
  logic [31:0]                   ph;
  erm_pkg::rot_t                 rot_q;

  // Stage 1: wrap to one turn and split floor((a*2^32 + 18000) / 36000)
  // into a*TurnQuot plus floor((a*RemScaled + HalfScaled) / 1125).
  always_comb begin
    if ({1'b0, angle_i} >= 17'(erm_pkg::FullTurnCenti)) begin
      wrapped = angle_i - 16'(erm_pkg::FullTurnCenti);
    end else begin
      wrapped = angle_i;
    end
    base_d = 32'(33'(wrapped) * 33'(TurnQuot));
    rem_d  = 25'(25'(wrapped) * 25'(RemScaled)) + 25'(HalfScaled);
  end

  always_ff @(posedge clk_i) begin
    base_q <= base_d;
    rem_q  <= rem_d;
  end

  // Stage 2: divide the small remainder by 1125 with a reciprocal multiply.
  always_comb begin
    prod = 50'(rem_q) * 50'(RecipMul);
    ph   = base_q + 32'(prod >> RecipShift);
  end

  always_ff @(posedge clk_i) begin
    rot_q.x    <= $signed({2'b00, erm_pkg::GainStart});
    rot_q.y    <= '0;
    rot_q.z    <= $signed({3'b000, ph[29:0]});
    rot_q.quad <= ph[31:30];
  end

  assign rot_o = rot_q;

endmodule : erm_phase
`default_nettype wire

### sv/erm_cell.sv
`default_nettype none
// ---------------------------------------------------------------------------
// erm_cell: one CORDIC micro-rotation
// Rotates the record by atan(2^-STAGE) and hands it to the next cell.
// ---------------------------------------------------------------------------
module erm_cell #(
  parameter int STAGE = 0
) (
  input  wire logic  clk_i,
  input  erm_pkg::rot_t rot_i,
  output erm_pkg::rot_t rot_o
);

  erm_pkg::rot_t rot_d, rot_q;
  logic signed [erm_pkg::XyBits-1:0] dx, dy;

  always_comb begin
    dx    = rot_i.y >>> STAGE;
    dy    = rot_i.x >>> STAGE;
    rot_d = rot_i;
    if (!rot_i.z[erm_pkg::ZBits-1]) begin
      rot_d.x = rot_i.x - dx;
      rot_d.y = rot_i.y + dy;
      rot_d.z = rot_i.z - erm_pkg::atan_turn(STAGE);
    end else begin
      rot_d.x = rot_i.x + dx;
      rot_d.y = rot_i.y - dy;
      rot_d.z = rot_i.z + erm_pkg::atan_turn(STAGE);
    end
  end

  always_ff @(posedge clk_i) begin
    rot_q <= rot_d;
  end

  assign rot_o = rot_q;

endmodule : erm_cell
`default_nettype wire

### sv/erm_sincos.sv
`default_nettype none
// ---------------------------------------------------------------------------
// erm_sincos: sine and cosine of one angle
// Phase unit, a chain of CORDIC cells, then rounding, saturation and
// quadrant fold-back.
// ---------------------------------------------------------------------------
module erm_sincos #(
  parameter int FRAC_BITS     = erm_pkg::FracBitsDef,
  parameter int CORDIC_STAGES = erm_pkg::CordicStagesDef
) (
  input  wire logic                          clk_i,
  input  wire logic [erm_pkg::AngleBits-1:0] angle_i,
  output logic signed [FRAC_BITS+1:0]        sin_o,
  output logic signed [FRAC_BITS+1:0]        cos_o
);

  localparam int NCells = (CORDIC_STAGES > 32) ? 32 : CORDIC_STAGES;
  localparam int Sh     = erm_pkg::WorkBits - FRAC_BITS;
  localparam int Rb     = erm_pkg::XyBits - Sh + 1;

  erm_pkg::rot_t chain [NCells+1];

  erm_phase u_phase (
    .clk_i   (clk_i),
    .angle_i (angle_i),
    .rot_o   (chain[0])
  );

  for (genvar g = 0; g < NCells; g++) begin : g_cell
    erm_cell #(.STAGE(g)) u_cell (
      .clk_i (clk_i),
      .rot_i (chain[g]),
      .rot_o (chain[g+1])
    );
  end

  function automatic logic signed [FRAC_BITS+1:0] rnd_sat(
    input logic signed [erm_pkg::XyBits-1:0] v
  );
    logic signed [erm_pkg::XyBits:0] t;
    logic signed [Rb-1:0]            r;
    logic signed [Rb-1:0]            one;
    t   = {v[erm_pkg::XyBits-1], v} + ((erm_pkg::XyBits+1)'(1) <<< (Sh - 1));
    r   = Rb'(t >>> Sh);
    one = Rb'(1) <<< FRAC_BITS;
    if (r > one) r = one;
    else if (r < -one) r = -one;
    return (FRAC_BITS+2)'(r);
  endfunction

  logic signed [FRAC_BITS+1:0] s, c;

  always_comb begin
    s = rnd_sat(chain[NCells].y);
    c = rnd_sat(chain[NCells].x);
  end

  always_ff @(posedge clk_i) begin
    case (chain[NCells].quad)
      2'd0: begin sin_o <= s;  cos_o <= c;  end
      2'd1: begin sin_o <= c;  cos_o <= -s; end
      2'd2: begin sin_o <= -s; cos_o <= -c; end
      default: begin sin_o <= -c; cos_o <= s; end
    endcase
  end

endmodule : erm_sincos
`default_nettype wire

### sv/erm_matrix.sv
`default_nettype none
// ---------------------------------------------------------------------------
// erm_matrix: rotation matrix products
// Three registered stages: pair products, triple products, sums and
// saturation to plus or minus one.
// ---------------------------------------------------------------------------
module erm_matrix #(
  parameter int FRAC_BITS = erm_pkg::FracBitsDef
) (
  input  wire logic                         clk_i,
  input  wire logic signed [FRAC_BITS+1:0]  sx_i, cx_i, sy_i, cy_i, sz_i, cz_i,
  output logic [erm_pkg::ElemBits-1:0]      elem_o [9]
);

  localparam int W = FRAC_BITS + 2;
  localparam int P = 2 * W;

  function automatic logic signed [W-1:0] fmul(input logic signed [W-1:0] a,
                                                input logic signed [W-1:0] b);
    logic signed [P-1:0] m;
    m = a * b + (P'(1) <<< (FRAC_BITS - 1));
    return W'(m >>> FRAC_BITS);
  endfunction

  function automatic logic [erm_pkg::ElemBits-1:0] sat(input logic signed [W:0] v);
    logic signed [W:0] one, r;
    one = (W+1)'(1) <<< FRAC_BITS;
    r   = (v > one) ? one : ((v < -one) ? -one : v);
    return erm_pkg::ElemBits'(r);
  endfunction

  // Stage 1
  logic signed [W-1:0] sxsy_q, cxsy_q, cysz_q, cycz_q, cxsz_q, sxsz_q, cxcz_q, sxcz_q;
  logic signed [W-1:0] nsy_q, sxcy_q, cxcy_q, sz_q, cz_q;
  always_ff @(posedge clk_i) begin
    sxsy_q <= fmul(sx_i, sy_i);  cxsy_q <= fmul(cx_i, sy_i);
    cycz_q <= fmul(cy_i, cz_i);  cysz_q <= fmul(cy_i, sz_i);
    cxsz_q <= fmul(cx_i, sz_i);  sxsz_q <= fmul(sx_i, sz_i);
    cxcz_q <= fmul(cx_i, cz_i);  sxcz_q <= fmul(sx_i, cz_i);
    sxcy_q <= fmul(sx_i, cy_i);  cxcy_q <= fmul(cx_i, cy_i);
    nsy_q  <= -sy_i;
    sz_q   <= sz_i;              cz_q   <= cz_i;
  end

  // Stage 2
  logic signed [W-1:0] t1_q, t2_q, t4_q, t5_q;
  logic signed [W-1:0] a0_q, b1_q, b2_q, a3_q, b4_q, b5_q, a6_q, a7_q, a8_q;
  always_ff @(posedge clk_i) begin
    t1_q <= fmul(sxsy_q, cz_q);  t2_q <= fmul(cxsy_q, cz_q);
    t4_q <= fmul(sxsy_q, sz_q);  t5_q <= fmul(cxsy_q, sz_q);
    a0_q <= cycz_q;  b1_q <= cxsz_q;  b2_q <= sxsz_q;  a3_q <= cysz_q;
    b4_q <= cxcz_q;  b5_q <= sxcz_q;  a6_q <= nsy_q;   a7_q <= sxcy_q;
    a8_q <= cxcy_q;
  end

  // Stage 3
  always_ff @(posedge clk_i) begin
    elem_o[0] <= sat({a0_q[W-1], a0_q});
    elem_o[1] <= sat({t1_q[W-1], t1_q} - {b1_q[W-1], b1_q});
    elem_o[2] <= sat({t2_q[W-1], t2_q} + {b2_q[W-1], b2_q});
    elem_o[3] <= sat({a3_q[W-1], a3_q});
    elem_o[4] <= sat({t4_q[W-1], t4_q} + {b4_q[W-1], b4_q});
    elem_o[5] <= sat({t5_q[W-1], t5_q} - {b5_q[W-1], b5_q});
    elem_o[6] <= sat({a6_q[W-1], a6_q});
    elem_o[7] <= sat({a7_q[W-1], a7_q});
    elem_o[8] <= sat({a8_q[W-1], a8_q});
  end

endmodule : erm_matrix
`default_nettype wire

### sim/euler_rotation_matrix_checker.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// euler_rotation_matrix_checker: matrix predictor and result scoreboard
// Watches the angle beats taken by the block and predicts the nine Q1.14
// matrix elements of each one. Every done_o beat is compared, element by
// element, against the oldest prediction still waiting.
// ---------------------------------------------------------------------------
module euler_rotation_matrix_checker (
  input  wire logic                          clk_i,
  input  wire logic                          start_i,
  input  wire logic                          busy_i,
  input  wire logic [erm_pkg::AngleBits-1:0] angle_x_i,
  input  wire logic [erm_pkg::AngleBits-1:0] angle_y_i,
  input  wire logic [erm_pkg::AngleBits-1:0] angle_z_i,
  input  wire logic                          done_i,
  input  wire logic [8:0][erm_pkg::ElemBits-1:0] elems_i,
  output int                                 pending_o,
  output int                                 errors_o
);

  localparam int FracBits = erm_pkg::FracBitsDef;
  localparam int Stages   = erm_pkg::CordicStagesDef;
  localparam longint One  = longint'(1) << FracBits;

  typedef logic [8:0][erm_pkg::ElemBits-1:0] matrix_t;

  matrix_t matrix_q[$];

  longint turn_step [32] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
    41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20, 10,
    5, 3, 1, 1, 0};

  function automatic longint clamp_unit(longint v);
    if (v > One) return One;
    if (v < -One) return -One;
    return v;
  endfunction

  function automatic longint round_down(longint v, int s);
    return (v + (longint'(1) << (s - 1))) >>> s;
  endfunction

  function automatic longint qmul(longint a, longint b);
    return round_down(a * b, FracBits);
  endfunction

  // Sine and cosine of an angle in hundredths of a degree, Q1.14.
  function automatic void angle_trig(input logic [15:0] centi, output longint sn,
                                     output longint cs);
    longint a, phase, z, x, y, dx, dy, c, s;
    logic [1:0] quad;
    a = longint'(centi) % 36000;
    phase = ((a << 32) + 18000) / 36000;
    quad = phase[31:30];
    z = phase & 64'h3FFF_FFFF;
    x = longint'(64'd2608131496) << 16;
    y = 0;
    for (int i = 0; i < Stages && i < 32; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= turn_step[i];
      end else begin
        x += dx; y -= dy; z += turn_step[i];
      end
    end
    c = clamp_unit(round_down(x, erm_pkg::WorkBits - FracBits));
    s = clamp_unit(round_down(y, erm_pkg::WorkBits - FracBits));
    case (quad)
      2'd0: begin sn = s;  cs = c;  end
      2'd1: begin sn = c;  cs = -s; end
      2'd2: begin sn = -s; cs = -c; end
      default: begin sn = -c; cs = s; end
    endcase
  endfunction

  function automatic matrix_t rotation_of(logic [15:0] ax, logic [15:0] ay, logic [15:0] az);
    longint sx, cx, sy, cy, sz, cz, sxsy, cxsy;
    longint e [9];
    matrix_t m;
    angle_trig(ax, sx, cx);
    angle_trig(ay, sy, cy);
    angle_trig(az, sz, cz);
    sxsy = qmul(sx, sy);
    cxsy = qmul(cx, sy);
    e[0] = clamp_unit(qmul(cy, cz));
    e[1] = clamp_unit(qmul(sxsy, cz) - qmul(cx, sz));
    e[2] = clamp_unit(qmul(cxsy, cz) + qmul(sx, sz));
    e[3] = clamp_unit(qmul(cy, sz));
    e[4] = clamp_unit(qmul(sxsy, sz) + qmul(cx, cz));
    e[5] = clamp_unit(qmul(cxsy, sz) - qmul(sx, cz));
    e[6] = clamp_unit(-sy);
    e[7] = clamp_unit(qmul(sx, cy));
    e[8] = clamp_unit(qmul(cx, cy));
    for (int k = 0; k < 9; k++) m[k] = e[k][15:0];
    return m;
  endfunction

  initial errors_o = 0;
  assign pending_o = matrix_q.size();

  always @(posedge clk_i) begin
    matrix_t want;
    if (done_i) begin
      if (matrix_q.size() == 0) begin
        $display("%0t: result beat with no prediction waiting, got %h", $time, elems_i);
        errors_o++;
      end else begin
        want = matrix_q.pop_front();
        for (int k = 0; k < 9; k++) begin
          if (elems_i[k] !== want[k]) begin
            $display("%0t: element r%0dc%0d expected %0d got %0d", $time, k / 3, k % 3,
                     $signed(want[k]), $signed(elems_i[k]));
            errors_o++;
          end
        end
      end
    end
    if (start_i && !busy_i) matrix_q.push_back(rotation_of(angle_x_i, angle_y_i, angle_z_i));
  end

endmodule

### sim/euler_rotation_matrix_tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// euler_rotation_matrix_tb: testbench of the rotation matrix block
// Sends directed corner angles and then random angle triples, with phases
// of random sender gaps, and leaves all checking to the checker module.
// ---------------------------------------------------------------------------
module euler_rotation_matrix_tb;

  localparam int CycleLimit = 200000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  logic [15:0] angle_x_i = '0, angle_y_i = '0, angle_z_i = '0;
  logic busy_o, done_o;
  logic [8:0][15:0] elems;
  int pending, errors, cycles = 0, idle_pct = 0;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  euler_rotation_matrix u_dut (
    .clk_i, .rst_ni, .start_i, .busy_o, .angle_x_i, .angle_y_i, .angle_z_i, .done_o,
    .elem_r0c0_o(elems[0]), .elem_r0c1_o(elems[1]), .elem_r0c2_o(elems[2]),
    .elem_r1c0_o(elems[3]), .elem_r1c1_o(elems[4]), .elem_r1c2_o(elems[5]),
    .elem_r2c0_o(elems[6]), .elem_r2c1_o(elems[7]), .elem_r2c2_o(elems[8])
  );

  euler_rotation_matrix_checker u_checker (
    .clk_i, .start_i, .busy_i(busy_o), .angle_x_i, .angle_y_i, .angle_z_i,
    .done_i(done_o), .elems_i(elems), .pending_o(pending), .errors_o(errors)
  );

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Angles are mostly in range; some exercise the wrap above a full turn.
  function automatic logic [15:0] any_angle();
    if ($urandom_range(99) < 15) return 16'($urandom);
    return 16'($urandom_range(36000));
  endfunction

  // Drives one beat; busy_o is read in the low half of the clock, where it
  // holds the value that the next rising edge sees.
  task automatic send_angles(input logic [15:0] ax, input logic [15:0] ay,
                             input logic [15:0] az);
    int gap;
    bit taken;
    if ($urandom_range(99) < idle_pct) begin
      gap = $urandom_range(1, 4);
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i <= 1'b1;
    angle_x_i <= ax;
    angle_y_i <= ay;
    angle_z_i <= az;
    do begin
      @(negedge clk_i);
      taken = !busy_o;
      @(posedge clk_i);
    end while (!taken);
  endtask

  initial begin
    logic [15:0] corners [12] = '{0, 1, 4500, 8999, 9000, 18000, 27000, 35999,
                                  36000, 45000, 65535, 22500};
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (int i = 0; i < 12; i++) send_angles(corners[i], corners[(i + 4) % 12],
                                             corners[(i + 7) % 12]);
    send_angles(16'hFFFF, 16'h0000, 16'hAAAA);
    send_angles(16'h5555, 16'hFFFF, 16'h0000);
    send_angles(9000, 9000, 9000);
    send_angles(27000, 18000, 9000);
    // Hold off until the pipeline has drained completely.
    start_i <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    @(posedge clk_i);
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: idle_pct = 0;
        1: idle_pct = 46;
        2: idle_pct = 37;
        default: idle_pct = 0;
      endcase
      repeat (235) send_angles(any_angle(), any_angle(), any_angle());
    end
    start_i <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    repeat (30) @(posedge clk_i);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

### euler_rotation_matrix.f
sv/erm_pkg.sv
sv/erm_phase.sv
sv/erm_cell.sv
sv/erm_sincos.sv
sv/erm_matrix.sv
sv/euler_rotation_matrix.sv
sim/euler_rotation_matrix_checker.sv
sim/euler_rotation_matrix_tb.sv
